/* hw/rtl/srt_pkg.sv */
// shared constants, types and tables of the bfloat16 sine pipeline
package srt_pkg;

	localparam int INTERNAL_FRAC_BITS = 28;

	localparam int NUM_STAGES = 16;
	localparam int RED_STAGES = 7;
	localparam int POLY_STAGES = NUM_STAGES - RED_STAGES;

	localparam int TP_W = INTERNAL_FRAC_BITS + 3;
	localparam int R_W = INTERNAL_FRAC_BITS + 1;
	localparam int TBL_N = INTERNAL_FRAC_BITS + 15;
	localparam int TBL_IDX_W = $clog2(TBL_N);

	// pi scaled by 2^60, truncated
	localparam logic [63:0] PI_2P60 = 64'h3243F6A8885A308D;

	localparam logic [TP_W-1:0] PI_C = TP_W'(PI_2P60 >> (60 - INTERNAL_FRAC_BITS));
	localparam logic [TP_W-1:0] HALF_PI_C = TP_W'(PI_2P60 >> (61 - INTERNAL_FRAC_BITS));
	localparam logic [TP_W-1:0] TWO_PI_C = TP_W'(PI_2P60 >> (59 - INTERNAL_FRAC_BITS));

	localparam logic [63:0] FX_ONE = 64'd1 << INTERNAL_FRAC_BITS;
	localparam logic [INTERNAL_FRAC_BITS-1:0] INV6_C = INTERNAL_FRAC_BITS'(FX_ONE / 64'd6);
	localparam logic [INTERNAL_FRAC_BITS-1:0] INV120_C =
		INTERNAL_FRAC_BITS'(FX_ONE / 64'd120);

	typedef struct packed {
		logic neg;
		logic oor;
	} side_t;

	// 2^(p - INTERNAL_FRAC_BITS) mod 2pi in fixed point
	typedef logic [TP_W-1:0] mod_tbl_t [TBL_N];

	function automatic mod_tbl_t build_mod_tbl();
		mod_tbl_t tbl;
		logic [TP_W:0] acc;
		acc = (TP_W + 1)'(1);
		for (int p = 0; p < TBL_N; p++) begin
			tbl[p] = acc[TP_W-1:0];
			acc = acc << 1;
			if (acc >= {1'b0, TWO_PI_C}) begin
				acc = acc - {1'b0, TWO_PI_C};
			end
		end
		return tbl;
	endfunction

	localparam mod_tbl_t MOD_TBL = build_mod_tbl();

endpackage

/* hw/rtl/sine_range_reduce_taylor.sv */
// top level of the bfloat16 sine unit: pipeline control and the two datapath halves
//
// Takes one bfloat16 angle per cycle while in_ready is high and returns its
// bfloat16 sine through sixteen register stages that hold one request each; a
// stalled output only stops the stages behind it once they are full, so gaps
// close up. The angle is reduced modulo 2pi by summing, per mantissa bit, a
// constant 2^k mod 2pi and taking off at most eight multiples of 2pi, then folded
// into [0, pi/2] and run through r - r^3/6 + r^5/120 in 28-bit fraction fixed
// point, one multiplier level per stage, truncating. The magnitude is rounded to
// nearest even. Zero and subnormal angles give +0; Inf, NaN and magnitudes of at
// least 2^15 give +0 with out_of_range set. A zero result is always +0.
module sine_range_reduce_taylor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] angle_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] sine_bits,
	output logic        out_of_range
);
	import srt_pkg::*;

	localparam logic [NUM_STAGES-1:0] ALL_ONES = '1;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;
	logic [R_W-1:0] red_r;
	side_t red_side;

	// a stage moves when any stage from it to the output is empty or the output drains
	always_comb begin
		for (int k = 0; k < NUM_STAGES; k++) begin
			en[k] = out_ready || ((vld_q >> k) != (ALL_ONES >> k));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready = en[0];
	assign out_valid = vld_q[NUM_STAGES-1];

	srt_reduce u_reduce (
		.clk        (clk),
		.en         (en[RED_STAGES-1:0]),
		.angle_bits (angle_bits),
		.r          (red_r),
		.side       (red_side)
	);

	srt_poly u_poly (
		.clk          (clk),
		.en           (en[NUM_STAGES-1:RED_STAGES]),
		.r            (red_r),
		.side         (red_side),
		.sine_bits    (sine_bits),
		.out_of_range (out_of_range)
	);

`ifndef SYNTHESIS
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_q == ALL_ONES))
		else $error("input blocked with a bubble in the pipeline");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> sine_bits == 16'h0000)
		else $error("out of range request without +0 result");

	a_no_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sine_bits != 16'h8000)
		else $error("negative zero result");

	a_mag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sine_bits[14:7] <= 8'd127)
		else $error("sine magnitude of two or more");
`endif

endmodule

/* hw/rtl/srt_reduce.sv */
// decode and range reduction stages: angle to folded fixed-point argument
module srt_reduce (
	input  logic                              clk,
	input  logic [srt_pkg::RED_STAGES-1:0]    en,
	input  logic [15:0]                       angle_bits,
	output logic [srt_pkg::R_W-1:0]           r,
	output srt_pkg::side_t                    side
);
	import srt_pkg::*;

	localparam int SUM_W = TP_W + 4;
	localparam logic signed [9:0] SH_OFS = 10'(INTERNAL_FRAC_BITS - 134);

	typedef logic [SUM_W-1:0] kmult_t [8];

	function automatic kmult_t build_kmult();
		kmult_t t;
		logic [SUM_W-1:0] acc;
		acc = '0;
		for (int j = 0; j < 8; j++) begin
			acc = acc + SUM_W'(TWO_PI_C);
			t[j] = acc;
		end
		return t;
	endfunction

	localparam kmult_t KMULT = build_kmult();

	// stage 1: decode, one term per mantissa bit plus one for small angles
	logic [7:0] ex;
	logic [7:0] mt;
	logic signed [9:0] sh;
	logic [9:0] rsh;
	logic special;
	logic [TP_W-1:0] term_c [9];
	logic [TBL_IDX_W-1:0] idx;

	logic [TP_W-1:0] term_s1 [9];
	side_t side_s1;

	always_comb begin
		ex = angle_bits[14:7];
		mt = {1'b1, angle_bits[6:0]};
		sh = $signed({2'b00, ex}) + SH_OFS;
		rsh = 10'(-sh);
		special = (ex == 8'd0) || (ex >= 8'd142);
		idx = '0;
		for (int i = 0; i < 8; i++) begin
			idx = TBL_IDX_W'(sh) + TBL_IDX_W'(i);
			term_c[i] = (!special && !sh[9] && mt[i]) ? MOD_TBL[idx] : '0;
		end
		if (!special && sh[9] && (sh >= -10'sd8)) begin
			term_c[8] = TP_W'(mt >> rsh[3:0]);
		end else begin
			term_c[8] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			term_s1 <= term_c;
			side_s1.neg <= angle_bits[15];
			side_s1.oor <= ex >= 8'd142;
		end
	end

	// stage 2: partial sums
	logic [SUM_W-1:0] sum_a_c, sum_b_c;
	logic [SUM_W-1:0] sum_a_s2, sum_b_s2;
	side_t side_s2;

	always_comb begin
		sum_a_c = '0;
		sum_b_c = '0;
		for (int i = 0; i < 5; i++) begin
			sum_a_c = sum_a_c + SUM_W'(term_s1[i]);
		end
		for (int i = 5; i < 9; i++) begin
			sum_b_c = sum_b_c + SUM_W'(term_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sum_a_s2 <= sum_a_c;
			sum_b_s2 <= sum_b_c;
			side_s2 <= side_s1;
		end
	end

	// stage 3: total
	logic [SUM_W-1:0] total_s3;
	side_t side_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			total_s3 <= sum_a_s2 + sum_b_s2;
			side_s3 <= side_s2;
		end
	end

	// stage 4: modulo 2pi, quotient below nine
	logic [SUM_W-1:0] sel_c, qd_c;
	logic [TP_W-1:0] q_s4;
	side_t side_s4;

	always_comb begin
		sel_c = '0;
		for (int j = 0; j < 8; j++) begin
			if (total_s3 >= KMULT[j]) begin
				sel_c = KMULT[j];
			end
		end
		qd_c = total_s3 - sel_c;
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			q_s4 <= qd_c[TP_W-1:0];
			side_s4 <= side_s3;
		end
	end

	// stage 5: negative angles
	logic [TP_W-1:0] r_s5;
	side_t side_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			r_s5 <= (side_s4.neg && (q_s4 != '0)) ? TWO_PI_C - q_s4 : q_s4;
			side_s5 <= side_s4;
		end
	end

	// stage 6: half turn, sign of result
	logic [TP_W-1:0] r_s6;
	side_t side_s6;
	logic ge_pi;

	assign ge_pi = r_s5 >= PI_C;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			r_s6 <= ge_pi ? r_s5 - PI_C : r_s5;
			side_s6.neg <= ge_pi;
			side_s6.oor <= side_s5.oor;
		end
	end

	// stage 7: fold into [0, pi/2]
	logic [TP_W-1:0] r7_c;
	logic [R_W-1:0] r_s7;
	side_t side_s7;

	assign r7_c = (r_s6 > HALF_PI_C) ? PI_C - r_s6 : r_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			r_s7 <= r7_c[R_W-1:0];
			side_s7 <= side_s6;
		end
	end

	assign r = r_s7;
	assign side = side_s7;

endmodule

/* hw/rtl/srt_poly.sv */
// polynomial and bfloat16 rounding stages
module srt_poly (
	input  logic                              clk,
	input  logic [srt_pkg::POLY_STAGES-1:0]   en,
	input  logic [srt_pkg::R_W-1:0]           r,
	input  srt_pkg::side_t                    side,
	output logic [15:0]                       sine_bits,
	output logic                              out_of_range
);
	import srt_pkg::*;

	localparam int F = INTERNAL_FRAC_BITS;
	localparam int W2 = F + 2;
	localparam int W4 = F + 3;
	localparam int W5 = F + 4;
	localparam int Y_W = R_W;
	localparam int PW = $clog2(Y_W);
	localparam logic [PW-1:0] TOP_POS = PW'(Y_W - 1);
	localparam logic [7:0] EXP_OFS = 8'(127 - F);

	// stage 8: r^2
	logic [2*R_W-1:0] p2;
	logic [R_W-1:0] r_s8;
	logic [W2-1:0] r2_s8;
	side_t side_s8;

	assign p2 = r * r;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			r_s8 <= r;
			r2_s8 <= W2'(p2 >> F);
			side_s8 <= side;
		end
	end

	// stage 9: r^3
	logic [W2+R_W-1:0] p3;
	logic [R_W-1:0] r_s9;
	logic [W2-1:0] r3_s9;
	side_t side_s9;

	assign p3 = r2_s8 * r_s8;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			r_s9 <= r_s8;
			r3_s9 <= W2'(p3 >> F);
			side_s9 <= side_s8;
		end
	end

	// stage 10: r^4 and r^3/6
	logic [W2+R_W-1:0] p4;
	logic [W2+F-1:0] pt3;
	logic [R_W-1:0] r_s10;
	logic [W4-1:0] r4_s10;
	logic [F-1:0] t3_s10;
	side_t side_s10;

	assign p4 = r3_s9 * r_s9;
	assign pt3 = r3_s9 * INV6_C;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			r_s10 <= r_s9;
			r4_s10 <= W4'(p4 >> F);
			t3_s10 <= F'(pt3 >> F);
			side_s10 <= side_s9;
		end
	end

	// stage 11: r^5 and r - r^3/6
	logic [W4+R_W-1:0] p5;
	logic [W5-1:0] r5_s11;
	logic [R_W-1:0] d_s11;
	side_t side_s11;

	assign p5 = r4_s10 * r_s10;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			r5_s11 <= W5'(p5 >> F);
			d_s11 <= r_s10 - R_W'(t3_s10);
			side_s11 <= side_s10;
		end
	end

	// stage 12: r^5/120
	logic [W5+F-1:0] pt5;
	logic [F-1:0] t5_s12;
	logic [R_W-1:0] d_s12;
	side_t side_s12;

	assign pt5 = r5_s11 * INV120_C;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			t5_s12 <= F'(pt5 >> F);
			d_s12 <= d_s11;
			side_s12 <= side_s11;
		end
	end

	// stage 13: sum
	logic [Y_W-1:0] y_s13;
	side_t side_s13;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			y_s13 <= d_s12 + R_W'(t5_s12);
			side_s13 <= side_s12;
		end
	end

	// stage 14: leading one
	logic [PW-1:0] lead_c;
	logic [Y_W-1:0] y_s14;
	logic [PW-1:0] lead_s14;
	logic nz_s14;
	side_t side_s14;

	always_comb begin
		lead_c = '0;
		for (int i = 0; i < Y_W; i++) begin
			if (y_s13[i]) begin
				lead_c = PW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			y_s14 <= y_s13;
			lead_s14 <= lead_c;
			nz_s14 <= |y_s13;
			side_s14 <= side_s13;
		end
	end

	// stage 15: normalize, round decision
	logic [Y_W-1:0] norm;
	logic [7:0] mant_s15;
	logic rup_s15;
	logic [PW-1:0] lead_s15;
	logic nz_s15;
	side_t side_s15;

	assign norm = y_s14 << (TOP_POS - lead_s14);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			mant_s15 <= norm[Y_W-1 -: 8];
			rup_s15 <= norm[Y_W-9] && ((|norm[Y_W-10:0]) || norm[Y_W-8]);
			lead_s15 <= lead_s14;
			nz_s15 <= nz_s14;
			side_s15 <= side_s14;
		end
	end

	// stage 16: pack
	logic [8:0] msum;
	logic [7:0] exp_c;
	logic [15:0] bits_c;
	logic [15:0] sine_s16;
	logic oor_s16;

	always_comb begin
		msum = {1'b0, mant_s15} + 9'(rup_s15);
		exp_c = 8'(lead_s15) + EXP_OFS + 8'(msum[8]);
		bits_c = nz_s15 ? {side_s15.neg, exp_c, msum[6:0]} : 16'h0000;
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			sine_s16 <= bits_c;
			oor_s16 <= side_s15.oor;
		end
	end

	assign sine_bits = sine_s16;
	assign out_of_range = oor_s16;

endmodule
